// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the section address translator.
// Concurrent checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check that is switched off while reset is high.
`define SRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SRA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SRA_ASSERT(label, clk, rst, prop, msg)
`define SRA_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: hw/rtl/sra_pkg.sv
// Shared types and constants of the section address translator.
// No dependencies; used by section_rva_to_offset.
package sra_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int COUNT_W = 8;
  localparam int EIDX_W  = 7;
  localparam int WORD_W  = 32;

  // Input tdata layout, lowest bit first.
  localparam int EIDX_LSB  = 0;
  localparam int BASE_LSB  = EIDX_LSB + EIDX_W;
  localparam int VSIZE_LSB = BASE_LSB + WORD_W;
  localparam int RSIZE_LSB = VSIZE_LSB + WORD_W;
  localparam int ROFF_LSB  = RSIZE_LSB + WORD_W;
  localparam int RVA_LSB   = ROFF_LSB + WORD_W;
  localparam int IN_BITS   = RVA_LSB + WORD_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Meaning of the input tuser bit.
  localparam logic FUNC_WRITE     = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  // One table entry as it sits in the memory.
  typedef struct packed {
    logic [WORD_W-1:0] raw_offset;
    logic [WORD_W-1:0] raw_size;
    logic [WORD_W-1:0] virt_size;
    logic [WORD_W-1:0] base;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

// File: hw/rtl/sra_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module sra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/section_rva_to_offset.sv
// Top level of the section address translator: section table and search sequencer.
// Depends on sra_pkg, sra_ram and assert_macros.svh.
//
// Usage. The input stream carries two kinds of beat, chosen by s_tuser.
// A write beat (s_tuser = 0) stores one section descriptor at entry_index;
// the block is ready again on the next cycle. A write at an index beyond
// the table is dropped. A translate beat (s_tuser = 1) carries an address;
// the block searches entries 0 up to section_count - 1 (at most the table
// size) and sends one result beat: the file offset in m_tdata and the found
// flag in m_tuser. Nothing is sent for a write beat. The search reads one
// table entry per cycle from a single memory read port and checks it with
// one shared subtract-and-compare unit; it stops at the first entry that
// hits, or after the last entry on a miss (count capped at the table size).
// s_tready is low for the whole search. The result sits in an output register;
// when the receiver stalls, the block holds it there and waits in its final
// state until the register is free. Reset clears section_count to zero and
// drops any result in flight; table contents are not cleared and an entry
// must be written before a search reaches it. section_count is written on
// the cfg channel, which is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module section_rva_to_offset (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write: cfg_data is section_count.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sra_pkg::COUNT_W-1:0]  cfg_data,
  // Input stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata from bit 0: entry_index[6:0], section_base[38:7],
  // section_virt_size[70:39], section_raw_size[102:71],
  // section_raw_offset[134:103], rva[166:135], zero pad [167].
  input  logic [sra_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: func (0 write, 1 translate).
  input  logic                         s_tuser,
  // Output stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata: file_offset[31:0].
  output logic [sra_pkg::WORD_W-1:0]   m_tdata,
  // m_tuser: found.
  output logic                         m_tuser
);

  `include "assert_macros.svh"

  localparam int IDX_W  = sra_pkg::IDX_W;
  localparam int CNT_W  = sra_pkg::CNT_W;
  localparam int WORD_W = sra_pkg::WORD_W;

  sra_pkg::state_t state, state_next;

  logic [sra_pkg::COUNT_W-1:0] section_count;
  logic [CNT_W-1:0]            limit;
  logic [CNT_W-1:0]            rd_idx;
  logic                        chk_valid;
  logic [WORD_W-1:0]           addr;
  logic                        hit;
  logic [WORD_W-1:0]           diff_q;
  logic [WORD_W-1:0]           off_q;

  logic                        in_acc;
  logic                        idx_ok;
  logic                        ram_we;
  logic                        issue;
  logic                        out_load;
  logic                        scan_end;
  logic                        match;
  sra_pkg::entry_t             wr_entry;
  sra_pkg::entry_t             rd_entry;
  logic [$bits(sra_pkg::entry_t)-1:0] rd_raw;
  logic [WORD_W-1:0]           span;
  logic [WORD_W:0]             diff;
  logic [WORD_W-1:0]           result;

  assign cfg_ready = 1'b1;

  // Search length: the configured count, capped at the table size.
  assign limit = (32'(section_count) > 32'(sra_pkg::MAX_ENTRIES)) ?
                 CNT_W'(sra_pkg::MAX_ENTRIES) : CNT_W'(section_count);

  assign idx_ok = 32'(s_tdata[sra_pkg::EIDX_LSB +: sra_pkg::EIDX_W]) <
                  32'(sra_pkg::MAX_ENTRIES);

  assign wr_entry.base       = s_tdata[sra_pkg::BASE_LSB +: WORD_W];
  assign wr_entry.virt_size  = s_tdata[sra_pkg::VSIZE_LSB +: WORD_W];
  assign wr_entry.raw_size   = s_tdata[sra_pkg::RSIZE_LSB +: WORD_W];
  assign wr_entry.raw_offset = s_tdata[sra_pkg::ROFF_LSB +: WORD_W];

  sra_ram #(
    .WIDTH ($bits(sra_pkg::entry_t)),
    .DEPTH (sra_pkg::MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(s_tdata[sra_pkg::EIDX_LSB +: sra_pkg::EIDX_W])),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_raw)
  );

  // Shared check unit: the entry read last cycle against the address.
  // The address lies in the entry when it is at or above the base and its
  // distance from the base is below the span; this never wraps.
  always_comb begin
    rd_entry = sra_pkg::entry_t'(rd_raw);
    span     = (rd_entry.virt_size == '0) ? rd_entry.raw_size : rd_entry.virt_size;
    diff     = {1'b0, addr} - {1'b0, rd_entry.base};
    match    = chk_valid && !diff[WORD_W] && (diff[WORD_W-1:0] < span);
  end

  assign scan_end = (rd_idx == limit);
  assign result   = hit ? (diff_q + off_q) : '0;

  // Sequencer outputs.
  always_comb begin
    s_tready = (state == sra_pkg::ST_IDLE);
    in_acc   = s_tvalid && s_tready;
    ram_we   = in_acc && (s_tuser == sra_pkg::FUNC_WRITE) && idx_ok;
    issue    = (state == sra_pkg::ST_SCAN) && (rd_idx < limit);
    out_load = (state == sra_pkg::ST_FINISH) && (!m_tvalid || m_tready);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sra_pkg::ST_IDLE: begin
        if (in_acc && (s_tuser == sra_pkg::FUNC_TRANSLATE)) begin
          state_next = sra_pkg::ST_SCAN;
        end
      end
      sra_pkg::ST_SCAN: begin
        if (match || scan_end) begin
          state_next = sra_pkg::ST_FINISH;
        end
      end
      sra_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = sra_pkg::ST_IDLE;
        end
      end
      default: state_next = sra_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sra_pkg::ST_IDLE;
      section_count <= '0;
      chk_valid     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        section_count <= cfg_data;
      end
      chk_valid <= issue;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr   <= s_tdata[sra_pkg::RVA_LSB +: WORD_W];
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    if (state == sra_pkg::ST_SCAN) begin
      if (match) begin
        hit    <= 1'b1;
        diff_q <= diff[WORD_W-1:0];
        off_q  <= rd_entry.raw_offset;
      end else if (scan_end) begin
        hit <= 1'b0;
      end
    end
    if (out_load) begin
      m_tdata <= result;
      m_tuser <= hit;
    end
  end

  `SRA_ASSERT(a_miss_zero, clk, rst, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "miss with nonzero offset")
  `SRA_ASSERT(a_out_from_finish, clk, rst, $rose(m_tvalid) |-> $past(state == sra_pkg::ST_FINISH), "result raised outside finish")
  `SRA_ASSERT(a_scan_bound, clk, rst, (state == sra_pkg::ST_SCAN) |-> (rd_idx <= limit), "scan ran past the count")
  `SRA_ASSERT(a_scan_exit, clk, rst, (state == sra_pkg::ST_SCAN) |=> (state == sra_pkg::ST_SCAN || state == sra_pkg::ST_FINISH), "scan left to the wrong state")

endmodule
